### hdl/stsir_pkg.sv
// ---------------------------------------------------------------------------
// stsir_pkg
// shared types, codes and defaults for the sorted key/data table
// ---------------------------------------------------------------------------
package stsir_pkg;

    // default sizing
    localparam int STSIR_CAPACITY  = 64;
    localparam int STSIR_KEY_BITS  = 64;
    localparam int STSIR_DATA_BITS = 32;

    // operation codes (code three runs as find)
    localparam logic [1:0] MODE_FIND   = 2'd0;
    localparam logic [1:0] MODE_INSERT = 2'd1;
    localparam logic [1:0] MODE_REMOVE = 2'd2;
    localparam logic [1:0] MODE_SPARE  = 2'd3;

    // result status codes
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
    localparam logic [1:0] STAT_DUPLICATE = 2'd2;
    localparam logic [1:0] STAT_FULL      = 2'd3;

    typedef struct packed {
        logic [1:0]  mode;
        logic [63:0] key;
        logic [31:0] entry_data;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [6:0]  rank;
        logic [31:0] found_data;
        logic [6:0]  entry_total;
    } t_out_item;

    // broadcast command to every cell
    typedef struct packed {
        logic cmp;
        logic ins;
        logic rem;
    } t_cell_cmd;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

endpackage

### hdl/sorted_table_search_insert_remove.sv
// ---------------------------------------------------------------------------
// sorted_table_search_insert_remove
// sorted key/data table with find, insert and remove over a chain of slots
// ---------------------------------------------------------------------------
//
//  channel   valid          stall          payload
//  -------   ------------   ------------   -----------------------------
//  input     i_in_valid     o_in_stall     i_in  (mode, key, entry_data)
//  output    o_out_valid    i_out_stall    o_out (status, rank,
//                                                 found_data, entry_total)
//
//  for each item, on the accept edge every slot compares its
//  key against the query in parallel; the execute state then encodes the rank,
//  writes the result register and shifts the chain on insert or remove
//  the next item is taken once the previous result is written, while that
//  result may still wait in the output register
//  if a result is still stalled, the execute state holds until it leaves
//  synchronous active-low reset empties the table (count to zero); slot
//  contents are not cleared since only slots below the count are looked at
//
module sorted_table_search_insert_remove #(
    parameter int CAPACITY  = stsir_pkg::STSIR_CAPACITY,
    parameter int KEY_BITS  = stsir_pkg::STSIR_KEY_BITS,
    parameter int DATA_BITS = stsir_pkg::STSIR_DATA_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  stsir_pkg::t_in_item   i_in,
    output logic                  o_in_stall,
    output logic                  o_out_valid,
    output stsir_pkg::t_out_item  o_out,
    input  logic                  i_out_stall
);
    import stsir_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    t_state               r_state;
    t_state               n_state;
    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     n_count;
    logic [1:0]           r_mode;
    logic [KEY_BITS-1:0]  r_key;
    logic [31:0]          r_data;
    logic                 r_out_valid;
    t_out_item            r_out;
    t_out_item            n_out;

    logic                 in_acc;
    logic                 fire;
    t_cell_cmd            cmd;

    // per-slot wiring, with a fixed "at most" on the low end and "above"
    // on the high end of the chain
    logic [CAPACITY:0]    le_ext;
    logic [CAPACITY-1:0]  le_vec;
    logic [CAPACITY-1:0]  eq_vec;
    logic [KEY_BITS-1:0]  key_arr  [CAPACITY];
    logic [DATA_BITS-1:0] data_arr [CAPACITY];

    logic [63:0]          din_w;
    logic [DATA_BITS-1:0] new_data;
    logic [CNT_W-1:0]     above;
    logic [DATA_BITS-1:0] hit_data;
    logic                 hit;
    logic                 full;
    logic [63:0]          rank_w;
    logic [63:0]          fdata_w;
    logic [63:0]          total_w;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign fire       = (r_state == S_EXEC) && (!r_out_valid || !i_out_stall);

    assign din_w    = {32'd0, r_data};
    assign new_data = din_w[DATA_BITS-1:0];

    // ---- chain of slots ----
    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic                 left_le;
            logic [KEY_BITS-1:0]  left_key;
            logic [DATA_BITS-1:0] left_data;
            logic                 right_le;
            logic [KEY_BITS-1:0]  right_key;
            logic [DATA_BITS-1:0] right_data;

            if (g == 0) begin : g_lo
                assign left_le   = 1'b1;
                assign left_key  = '0;
                assign left_data = '0;
            end else begin : g_lo
                assign left_le   = le_vec[g-1];
                assign left_key  = key_arr[g-1];
                assign left_data = data_arr[g-1];
            end

            if (g == CAPACITY - 1) begin : g_hi
                assign right_le   = 1'b0;
                assign right_key  = key_arr[g];
                assign right_data = data_arr[g];
            end else begin : g_hi
                assign right_le   = le_vec[g+1];
                assign right_key  = key_arr[g+1];
                assign right_data = data_arr[g+1];
            end

            stsir_cell #(
                .IDX       (g),
                .KEY_BITS  (KEY_BITS),
                .DATA_BITS (DATA_BITS),
                .CNT_W     (CNT_W)
            ) u_cell (
                .i_clk        (i_clk),
                .i_cmd        (cmd),
                .i_count      (r_count),
                .i_qkey       (i_in.key[KEY_BITS-1:0]),
                .i_new_key    (r_key),
                .i_new_data   (new_data),
                .i_left_le    (left_le),
                .i_left_key   (left_key),
                .i_left_data  (left_data),
                .i_right_le   (right_le),
                .i_right_key  (right_key),
                .i_right_data (right_data),
                .o_le         (le_vec[g]),
                .o_eq         (eq_vec[g]),
                .o_key        (key_arr[g]),
                .o_data       (data_arr[g])
            );
        end
    endgenerate

    assign le_ext = {1'b0, le_vec};

    // ---- rank and hit data from the registered compare flags ----
    // slots at or below the query form a prefix; its top slot is the rank
    always_comb begin
        above    = '0;
        hit_data = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (le_ext[i] && !le_ext[i+1]) begin
                above = above | CNT_W'(i + 1);
            end
            if (eq_vec[i]) begin
                hit_data = hit_data | data_arr[i];
            end
        end
    end

    assign hit     = |eq_vec;
    assign full    = r_count >= CNT_W'(CAPACITY);
    assign rank_w  = 64'(above) - 64'd1;
    assign fdata_w = 64'(hit_data);

    // ---- control and result ----
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_out       = r_out;
        cmd.cmp     = in_acc;
        cmd.ins     = 1'b0;
        cmd.rem     = 1'b0;
        total_w     = 64'(r_count);
        n_out.status      = STAT_OK;
        n_out.rank        = rank_w[6:0];
        n_out.found_data  = '0;
        n_out.entry_total = total_w[6:0];
        case (r_state)
            S_IDLE: begin
                n_out = r_out;
                if (in_acc) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                case (r_mode)
                    MODE_INSERT: begin
                        if (hit) begin
                            n_out.status = STAT_DUPLICATE;
                        end else if (full) begin
                            n_out.status = STAT_FULL;
                        end else begin
                            cmd.ins = fire;
                            n_count = r_count + CNT_W'(1);
                        end
                    end
                    MODE_REMOVE: begin
                        if (!hit) begin
                            n_out.status = STAT_NOT_FOUND;
                        end else begin
                            cmd.rem = fire;
                            n_count = r_count - CNT_W'(1);
                        end
                    end
                    default: begin
                        if (hit) begin
                            n_out.found_data = fdata_w[31:0];
                        end else begin
                            n_out.status = STAT_NOT_FOUND;
                        end
                    end
                endcase
                total_w           = 64'(n_count);
                n_out.entry_total = total_w[6:0];
                if (fire) begin
                    n_state = S_IDLE;
                end else begin
                    n_count = r_count;
                    n_out   = r_out;
                end
            end
            default: begin
                n_state = S_IDLE;
                n_out   = r_out;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // query and result payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_mode <= i_in.mode;
            r_key  <= i_in.key[KEY_BITS-1:0];
            r_data <= i_in.entry_data;
        end
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

`ifndef SYNTH
    // fill level never passes the table size
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    // table stays sorted: slots at or below the query form a prefix
    a_le_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |-> (((le_vec >> 1) & ~le_vec) == '0))
        else $error("compare flags not a prefix");

    // keys are unique, so at most one slot matches
    a_one_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |-> $onehot0(eq_vec))
        else $error("more than one slot matches the key");

    // a matching slot never lies above the rank slot
    a_hit_rank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |-> ((eq_vec & ~le_vec) == '0))
        else $error("matching slot above the rank");
`endif

endmodule

### hdl/stsir_cell.sv
// ---------------------------------------------------------------------------
// stsir_cell
// one table slot: holds key and data, compares against the query and
// shifts with its neighbors on insert or remove
// ---------------------------------------------------------------------------
module stsir_cell #(
    parameter int IDX       = 0,
    parameter int KEY_BITS  = 64,
    parameter int DATA_BITS = 32,
    parameter int CNT_W     = 7
) (
    input  logic                   i_clk,
    input  stsir_pkg::t_cell_cmd   i_cmd,
    input  logic [CNT_W-1:0]       i_count,
    input  logic [KEY_BITS-1:0]    i_qkey,
    input  logic [KEY_BITS-1:0]    i_new_key,
    input  logic [DATA_BITS-1:0]   i_new_data,
    // lower neighbor
    input  logic                   i_left_le,
    input  logic [KEY_BITS-1:0]    i_left_key,
    input  logic [DATA_BITS-1:0]   i_left_data,
    // upper neighbor
    input  logic                   i_right_le,
    input  logic [KEY_BITS-1:0]    i_right_key,
    input  logic [DATA_BITS-1:0]   i_right_data,
    output logic                   o_le,
    output logic                   o_eq,
    output logic [KEY_BITS-1:0]    o_key,
    output logic [DATA_BITS-1:0]   o_data
);
    import stsir_pkg::*;

    localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

    logic                 r_le;
    logic                 r_eq;
    logic [KEY_BITS-1:0]  r_key;
    logic [DATA_BITS-1:0] r_data;
    logic                 occ;

    assign occ = MY_IDX < i_count;

    always_ff @(posedge i_clk) begin
        if (i_cmd.cmp) begin
            r_le <= occ && (r_key <= i_qkey);
            r_eq <= occ && (r_key == i_qkey);
        end
        if (i_cmd.ins) begin
            // slot at the insert point takes the new entry, those above move up
            if (!r_le && i_left_le) begin
                r_key  <= i_new_key;
                r_data <= i_new_data;
            end else if (!i_left_le) begin
                r_key  <= i_left_key;
                r_data <= i_left_data;
            end
        end else if (i_cmd.rem) begin
            // removed slot and those above pull down
            if (!i_right_le) begin
                r_key  <= i_right_key;
                r_data <= i_right_data;
            end
        end
    end

    assign o_le   = r_le;
    assign o_eq   = r_eq;
    assign o_key  = r_key;
    assign o_data = r_data;

endmodule

### tb/stsir_table_checker.sv
// ---------------------------------------------------------------------------
// stsir_table_checker
// watches both channels of the sorted table, predicts and compares results
// ---------------------------------------------------------------------------
module stsir_table_checker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  stsir_pkg::t_in_item  i_in,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  stsir_pkg::t_out_item i_out,
    output int                   o_fail_count,
    output int                   o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import stsir_pkg::*;

    localparam int CAP = STSIR_CAPACITY;

    // shadow copy of the table
    logic [STSIR_KEY_BITS-1:0]  shadow_keys [CAP];
    logic [STSIR_DATA_BITS-1:0] shadow_data [CAP];
    int                         shadow_count;

    t_out_item op_outcomes [$];

    // runs one operation on the shadow table and returns its result
    function automatic t_out_item apply_table_op(t_in_item it);
        t_out_item res;
        int        above;
        logic      hit;
        above = 0;
        for (int i = 0; i < shadow_count; i++) begin
            if (shadow_keys[i] <= it.key) begin
                above = i + 1;
            end
        end
        hit = (above > 0) && (shadow_keys[above-1] == it.key);
        res.found_data = '0;
        case (it.mode)
            MODE_INSERT: begin
                if (hit) begin
                    res.status = STAT_DUPLICATE;
                end else if (shadow_count >= CAP) begin
                    res.status = STAT_FULL;
                end else begin
                    for (int i = shadow_count; i > above; i--) begin
                        shadow_keys[i] = shadow_keys[i-1];
                        shadow_data[i] = shadow_data[i-1];
                    end
                    shadow_keys[above] = it.key;
                    shadow_data[above] = it.entry_data;
                    shadow_count++;
                    res.status = STAT_OK;
                end
            end
            MODE_REMOVE: begin
                if (!hit) begin
                    res.status = STAT_NOT_FOUND;
                end else begin
                    for (int i = above - 1; i + 1 < shadow_count; i++) begin
                        shadow_keys[i] = shadow_keys[i+1];
                        shadow_data[i] = shadow_data[i+1];
                    end
                    shadow_count--;
                    res.status = STAT_OK;
                end
            end
            default: begin
                // find, and the spare code three
                if (hit) begin
                    res.status     = STAT_OK;
                    res.found_data = shadow_data[above-1];
                end else begin
                    res.status = STAT_NOT_FOUND;
                end
            end
        endcase
        res.rank        = 7'(above - 1);
        res.entry_total = 7'(shadow_count);
        return res;
    endfunction

    initial begin
        o_fail_count  = 0;
        o_outstanding = 0;
        shadow_count  = 0;
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            shadow_count = 0;
            op_outcomes.delete();
        end else begin
            // results first: an item accepted on this edge cannot answer yet
            if (i_out_valid && !i_out_stall) begin
                if (op_outcomes.size() == 0) begin
                    $error("result item with nothing outstanding: %p", i_out);
                    o_fail_count++;
                end else begin
                    want = op_outcomes.pop_front();
                    if (i_out.status !== want.status) begin
                        $error("status expected %0d actual %0d", want.status, i_out.status);
                        o_fail_count++;
                    end
                    if (i_out.rank !== want.rank) begin
                        $error("rank expected %0d actual %0d",
                               $signed(want.rank), $signed(i_out.rank));
                        o_fail_count++;
                    end
                    if (i_out.found_data !== want.found_data) begin
                        $error("found_data expected %h actual %h",
                               want.found_data, i_out.found_data);
                        o_fail_count++;
                    end
                    if (i_out.entry_total !== want.entry_total) begin
                        $error("entry_total expected %0d actual %0d",
                               want.entry_total, i_out.entry_total);
                        o_fail_count++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                op_outcomes.push_back(apply_table_op(i_in));
            end
        end
        o_outstanding = op_outcomes.size();
    end

endmodule

### tb/tb_sorted_table_search_insert_remove.sv
// ---------------------------------------------------------------------------
// tb_sorted_table_search_insert_remove
// drives find, insert and remove items into the sorted table with random
// idling and stalls; a checker beside the block predicts every result
// ---------------------------------------------------------------------------
module tb_sorted_table_search_insert_remove;
    timeunit 1ns;
    timeprecision 1ps;

    import stsir_pkg::*;

    localparam int RANDOM_ITEMS = 1700;
    localparam int POOL_SIZE    = 96;    // more codes than slots, so the table can fill
    localparam int HOLD_START   = 2500;  // receiver hold-off window, in cycles
    localparam int HOLD_CYCLES  = 200;
    localparam int CALM_START   = 3500;  // receiver never stalls in this window
    localparam int CALM_CYCLES  = 1000;

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      i_in_valid;
    t_in_item  i_in;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out;
    logic      i_out_stall;

    int fail_count;
    int outstanding;

    logic [63:0] code_pool [POOL_SIZE];

    always #1 i_clk = ~i_clk;

    sorted_table_search_insert_remove dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in        (i_in),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out       (o_out),
        .i_out_stall (i_out_stall)
    );

    stsir_table_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_in          (i_in),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_out         (o_out),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    // pack a code string big-endian, NUL-padded to eight bytes
    function automatic logic [63:0] pack_code(string s);
        logic [63:0] k;
        k = '0;
        for (int i = 0; i < 8 && i < s.len(); i++) begin
            k[63-8*i -: 8] = s[i];
        end
        return k;
    endfunction

    // mostly codes from the pool so finds and removes hit, with some noise
    function automatic logic [63:0] pick_key();
        int          r;
        logic [63:0] k;
        r = $urandom_range(0, 99);
        k = code_pool[$urandom_range(0, POOL_SIZE-1)];
        if (r < 78) begin
            return k;
        end else if (r < 86) begin
            return {$urandom, $urandom};
        end else if (r < 93) begin
            // neighbors of a stored code land between entries
            return ($urandom_range(0, 1) != 0) ? k + 64'd1 : k - 64'd1;
        end else if (r < 96) begin
            return '0;
        end
        return '1;
    endfunction

    // offer one item and hold it until the block takes it
    task automatic offer(logic [1:0] mode, logic [63:0] key, logic [31:0] data);
        t_in_item it;
        it.mode       = mode;
        it.key        = key;
        it.entry_data = data;
        i_in       <= it;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // receiver: random stalls, one long hold-off that backs up the block,
    // and a calm stretch with no stalls at all
    initial begin
        int cyc;
        cyc = 0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            cyc++;
            if (cyc >= HOLD_START && cyc < HOLD_START + HOLD_CYCLES) begin
                i_out_stall <= 1'b1;
            end else if (cyc >= CALM_START && cyc < CALM_START + CALM_CYCLES) begin
                i_out_stall <= 1'b0;
            end else begin
                i_out_stall <= ($urandom_range(0, 99) < 26);
            end
        end
    end

    // watchdog: well past the slowest legal run
    initial begin
        #400_000;
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        logic [63:0] milk;
        logic [1:0]  mode;
        int          r;
        int          ins_w;
        int          rem_w;
        int          len;

        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in       <= '0;

        // pool of upper-case codes of one to eight characters
        for (int p = 0; p < POOL_SIZE; p++) begin
            code_pool[p] = '0;
            len = $urandom_range(1, 8);
            for (int b = 0; b < len; b++) begin
                code_pool[p][63-8*b -: 8] = 8'($urandom_range(65, 90));
            end
        end
        milk = pack_code("MILK");

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty table, extremes of key and data, every operation
        offer(MODE_FIND,   '0,   '1);              // find on empty table
        offer(MODE_REMOVE, milk, '0);              // remove from empty table
        offer(MODE_SPARE,  '1,   '1);              // spare code three acts as find
        offer(MODE_INSERT, milk, 32'hCAFE_0001);
        offer(MODE_FIND,   pack_code("BREAD"), '0); // query below every key
        offer(MODE_INSERT, '1,   '1);              // largest key, largest data
        offer(MODE_INSERT, '0,   '0);              // smallest key
        offer(MODE_INSERT, milk, 32'h1234_5678);   // duplicate key
        offer(MODE_INSERT, pack_code("EGGS"), 32'h8000_0000);
        offer(MODE_FIND,   milk, '0);
        offer(MODE_FIND,   '1,   '0);
        offer(MODE_FIND,   pack_code("MILKY"), '0); // between two entries
        offer(MODE_SPARE,  pack_code("EGGS"), '1);
        offer(MODE_FIND,   '0,   '1);
        offer(MODE_REMOVE, pack_code("TEA"), '0);  // remove of absent key
        offer(MODE_REMOVE, '0,   '0);
        offer(MODE_FIND,   '0,   '0);              // now below every key
        offer(MODE_REMOVE, '1,   '0);
        offer(MODE_REMOVE, milk, '0);
        offer(MODE_REMOVE, pack_code("EGGS"), '0); // back to empty
        offer(MODE_FIND,   milk, '0);

        // random: phases lean toward filling, mixing or draining the table
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            case ((n / 160) % 4)
                0:       begin ins_w = 70; rem_w = 10; end
                2:       begin ins_w = 10; rem_w = 65; end
                default: begin ins_w = 35; rem_w = 30; end
            endcase
            r = $urandom_range(0, 99);
            if (r < 3) begin
                mode = MODE_SPARE;
            end else if (r < 3 + ins_w) begin
                mode = MODE_INSERT;
            end else if (r < 3 + ins_w + rem_w) begin
                mode = MODE_REMOVE;
            end else begin
                mode = MODE_FIND;
            end

            // idle cycles between items, none in the middle stretch
            if ((n < 800 || n >= 1100) && $urandom_range(0, 99) < 26) begin
                i_in_valid <= 1'b0;
                do @(posedge i_clk); while ($urandom_range(0, 99) < 26);
            end
            offer(mode, pick_key(), $urandom);
        end
        i_in_valid <= 1'b0;

        // drain, then allow the pipe to settle
        while (outstanding != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (fail_count == 0 && outstanding == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
